/* rtl/pxa_pkg.sv */
// ---------------------------------------------------------------------------
// pxa_pkg - shared types and constants for the pixel to ASCII downsampler
// Configuration record, queue entry, luminance mode codes and the 64-entry
// brightness ramp.
// ---------------------------------------------------------------------------
`default_nettype none

package pxa_pkg;

    localparam int CFG_W     = 13;   // size registers
    localparam int CHAN_W    = 3;    // channel count register
    localparam int CFG_IDX_W = 3;
    localparam int COMP_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int COORD_W   = 12;
    localparam int LUM_W     = 18;   // 1000 * 255 fits
    localparam int IDX_W     = 6;

    // idx = floor(lum * 63 / 255000) = (lum * RECIP) >> RECIP_SHIFT, exact for lum <= 255000
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 37;
    localparam logic [RECIP_W-1:0] RECIP = 26'd33955507;
    localparam int PROD_W      = LUM_W + RECIP_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

    typedef enum logic [1:0] {
        LUM_ZERO,
        LUM_GREY,
        LUM_RGB
    } t_lum_mode;

    typedef struct packed {
        logic [CFG_W-1:0]  image_width;
        logic [CFG_W-1:0]  image_height;
        logic [CFG_W-1:0]  out_width;
        logic [CFG_W-1:0]  out_height;
        logic [CHAN_W-1:0] channel_count;
    } t_pxa_cfg;

    typedef struct packed {
        t_lum_mode          mode;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic               row_end;
        logic               frame_end;
    } t_pxa_item;

    localparam logic [CHAR_W-1:0] RAMP [64] = '{
        7'h60, 7'h5E, 7'h22, 7'h2C, 7'h3A, 7'h3B, 7'h49, 7'h6C,
        7'h21, 7'h69, 7'h7E, 7'h2B, 7'h5F, 7'h2D, 7'h3F, 7'h5D,
        7'h5B, 7'h7D, 7'h28, 7'h31, 7'h29, 7'h28, 7'h7C, 7'h5C,
        7'h2F, 7'h74, 7'h66, 7'h6A, 7'h72, 7'h78, 7'h6E, 7'h75,
        7'h76, 7'h63, 7'h7A, 7'h58, 7'h59, 7'h55, 7'h4A, 7'h43,
        7'h4C, 7'h51, 7'h30, 7'h4F, 7'h5A, 7'h6D, 7'h77, 7'h71,
        7'h70, 7'h64, 7'h62, 7'h6B, 7'h68, 7'h61, 7'h6F, 7'h23,
        7'h4D, 7'h57, 7'h26, 7'h38, 7'h25, 7'h42, 7'h40, 7'h53
    };

endpackage

`default_nettype wire

/* rtl/pxa_front.sv */
// ---------------------------------------------------------------------------
// pxa_front - raster position tracking and nearest-neighbour selection
// Accepts pixels, keeps source and output positions and pushes one queue
// entry for every pixel that lands on an output cell.
// ---------------------------------------------------------------------------
`default_nettype none

module pxa_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_clear,
    input  pxa_pkg::t_pxa_cfg            i_cfg,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [pxa_pkg::COMP_W-1:0]    i_red,
    input  wire [pxa_pkg::COMP_W-1:0]    i_green,
    input  wire [pxa_pkg::COMP_W-1:0]    i_blue,
    input  wire                          i_full,
    output logic                         o_push,
    output pxa_pkg::t_pxa_item           o_item
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int AW = 2 * DW;

    function automatic logic [DW-1:0] fix_dim(input logic [pxa_pkg::CFG_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0)
            x = 32'd1;
        else if (x > 32'(MAX_DIMENSION))
            x = 32'(MAX_DIMENSION);
        return x[DW-1:0];
    endfunction

    logic [DW-1:0] w, h, ow, oh, ow_raw, oh_raw;

    logic [DW-1:0] r_sc, r_sr, r_oc, r_or;
    logic [DW-1:0] n_sc, n_sr, n_oc, n_or;
    logic [AW-1:0] r_cacc, r_racc, r_cbase, r_rbase;   // oc*w, or*h, sc*ow, sr*oh
    logic [AW-1:0] n_cacc, n_racc, n_cbase, n_rbase;

    logic          accept, row_pick, col_pick, pick, rend, fend;
    logic [DW:0]   sc_inc, sr_inc, oc_inc, or_inc;

    always_comb begin
        w      = fix_dim(i_cfg.image_width);
        h      = fix_dim(i_cfg.image_height);
        ow_raw = fix_dim(i_cfg.out_width);
        oh_raw = fix_dim(i_cfg.out_height);
        ow     = (ow_raw > w) ? w : ow_raw;
        oh     = (oh_raw > h) ? h : oh_raw;
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        sc_inc = {1'b0, r_sc} + 1'b1;
        sr_inc = {1'b0, r_sr} + 1'b1;
        oc_inc = {1'b0, r_oc} + 1'b1;
        or_inc = {1'b0, r_or} + 1'b1;

        // sr == floor(racc / oh)  <=>  sr*oh <= racc < sr*oh + oh
        row_pick = (r_or < oh) && (r_rbase <= r_racc) && (r_racc < r_rbase + AW'(oh));
        col_pick = (r_oc < ow) && (r_cbase <= r_cacc) && (r_cacc < r_cbase + AW'(ow));
        pick     = row_pick && col_pick;
        rend     = (oc_inc == {1'b0, ow});
        fend     = rend && (or_inc == {1'b0, oh});

        n_sc    = r_sc;
        n_sr    = r_sr;
        n_oc    = r_oc;
        n_or    = r_or;
        n_cacc  = r_cacc;
        n_racc  = r_racc;
        n_cbase = r_cbase;
        n_rbase = r_rbase;

        if (i_clear) begin
            n_sc    = '0;
            n_sr    = '0;
            n_oc    = '0;
            n_or    = '0;
            n_cacc  = '0;
            n_racc  = '0;
            n_cbase = '0;
            n_rbase = '0;
        end else if (accept) begin
            if (pick) begin
                n_oc   = oc_inc[DW-1:0];
                n_cacc = r_cacc + AW'(w);
            end
            if (sc_inc >= {1'b0, w}) begin
                if (sr_inc >= {1'b0, h}) begin
                    // last pixel of the frame
                    n_sc    = '0;
                    n_sr    = '0;
                    n_oc    = '0;
                    n_or    = '0;
                    n_cacc  = '0;
                    n_racc  = '0;
                    n_cbase = '0;
                    n_rbase = '0;
                end else begin
                    n_sc    = '0;
                    n_cbase = '0;
                    n_sr    = sr_inc[DW-1:0];
                    n_rbase = r_rbase + AW'(oh);
                    n_oc    = '0;
                    n_cacc  = '0;
                    if (row_pick) begin
                        n_or   = or_inc[DW-1:0];
                        n_racc = r_racc + AW'(h);
                    end
                end
            end else begin
                n_sc    = sc_inc[DW-1:0];
                n_cbase = r_cbase + AW'(ow);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= '0;
            r_sr    <= '0;
            r_oc    <= '0;
            r_or    <= '0;
            r_cacc  <= '0;
            r_racc  <= '0;
            r_cbase <= '0;
            r_rbase <= '0;
        end else begin
            r_sc    <= n_sc;
            r_sr    <= n_sr;
            r_oc    <= n_oc;
            r_or    <= n_or;
            r_cacc  <= n_cacc;
            r_racc  <= n_racc;
            r_cbase <= n_cbase;
            r_rbase <= n_rbase;
        end
    end

    assign o_push = accept && pick && !i_clear;

    always_comb begin
        if (i_cfg.channel_count >= 3'd3)
            o_item.mode = pxa_pkg::LUM_RGB;
        else if (i_cfg.channel_count == 3'd1)
            o_item.mode = pxa_pkg::LUM_GREY;
        else
            o_item.mode = pxa_pkg::LUM_ZERO;
        o_item.red       = i_red;
        o_item.green     = i_green;
        o_item.blue      = i_blue;
        o_item.column    = pxa_pkg::COORD_W'(r_oc);
        o_item.line      = pxa_pkg::COORD_W'(r_or);
        o_item.row_end   = rend;
        o_item.frame_end = fend;
    end

endmodule

`default_nettype wire

/* rtl/pxa_fifo.sv */
// ---------------------------------------------------------------------------
// pxa_fifo - short queue between selection and character generation
// Four entries, first-word fall-through.
// ---------------------------------------------------------------------------
`default_nettype none

module pxa_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  pxa_pkg::t_pxa_item  i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output pxa_pkg::t_pxa_item  o_item
);

    pxa_pkg::t_pxa_item                 r_mem [pxa_pkg::FIFO_DEPTH];
    logic [pxa_pkg::FIFO_PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [pxa_pkg::FIFO_CNT_W-1:0]     r_count;
    logic                               do_push, do_pop;

    assign o_full  = (r_count == pxa_pkg::FIFO_CNT_W'(pxa_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/pxa_back.sv */
// ---------------------------------------------------------------------------
// pxa_back - luminance, ramp index and character output
// Three stages: weighted sum, reciprocal multiply, ramp lookup into the
// output register. Each stage moves when the one after it is free.
// ---------------------------------------------------------------------------
`default_nettype none

module pxa_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  pxa_pkg::t_pxa_item              i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [pxa_pkg::CHAR_W-1:0]      o_char,
    output logic [pxa_pkg::COORD_W-1:0]     o_column,
    output logic [pxa_pkg::COORD_W-1:0]     o_line,
    output logic                            o_row_end,
    output logic                            o_frame_end
);

    typedef struct packed {
        logic [pxa_pkg::COORD_W-1:0] column;
        logic [pxa_pkg::COORD_W-1:0] line;
        logic                        row_end;
        logic                        frame_end;
    } t_meta;

    logic                           r_v1, r_v2, r_v3;
    logic                           en1, en2, en3;
    logic [pxa_pkg::LUM_W-1:0]      r_lum, n_lum;
    logic [pxa_pkg::IDX_W-1:0]      r_idx;
    logic [pxa_pkg::PROD_W-1:0]     prod;
    t_meta                          r_m1, r_m2, r_m3, in_meta;
    logic [pxa_pkg::CHAR_W-1:0]     r_char;

    assign en3   = !r_v3 || i_ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_valid && en1;

    always_comb begin
        case (i_item.mode)
            pxa_pkg::LUM_RGB:
                n_lum = pxa_pkg::LUM_W'(pxa_pkg::LUM_W'(i_item.red)   * 18'd299
                                      + pxa_pkg::LUM_W'(i_item.green) * 18'd587
                                      + pxa_pkg::LUM_W'(i_item.blue)  * 18'd114);
            pxa_pkg::LUM_GREY:
                n_lum = pxa_pkg::LUM_W'(pxa_pkg::LUM_W'(i_item.red) * 18'd1000);
            default:
                n_lum = '0;
        endcase
        in_meta.column    = i_item.column;
        in_meta.line      = i_item.line;
        in_meta.row_end   = i_item.row_end;
        in_meta.frame_end = i_item.frame_end;
    end

    assign prod = pxa_pkg::PROD_W'(r_lum) * pxa_pkg::PROD_W'(pxa_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_lum <= n_lum;
            r_m1  <= in_meta;
        end
        if (en2) begin
            r_idx <= prod[pxa_pkg::RECIP_SHIFT +: pxa_pkg::IDX_W];
            r_m2  <= r_m1;
        end
        if (en3) begin
            r_char <= pxa_pkg::RAMP[r_idx];
            r_m3   <= r_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1)
                r_v1 <= i_valid;
            if (en2)
                r_v2 <= r_v1;
            if (en3)
                r_v3 <= r_v2;
        end
    end

    assign o_valid     = r_v3;
    assign o_char      = r_char;
    assign o_column    = r_m3.column;
    assign o_line      = r_m3.line;
    assign o_row_end   = r_m3.row_end;
    assign o_frame_end = r_m3.frame_end;

endmodule

`default_nettype wire

/* rtl/pixel_to_ascii_downsampler_core.sv */
// ---------------------------------------------------------------------------
// pixel_to_ascii_downsampler_core - pixels in, ASCII art characters out
//
// Slave stream takes source pixels in raster order, one beat per pixel.
// Pixels that nearest-neighbour sampling picks yield one character beat on
// the master stream; all other pixels are consumed silently. tlast marks
// the last character of an output row, tuser the last of the frame.
// Configuration is a write-only register port (index, data, enable); any
// write restarts the frame. Write only while the stream side is idle.
//
// Throughput: one pixel per cycle while the queue is not full. A picked
// pixel's beat writes the queue; then luminance sum, reciprocal multiply
// and ramp lookup into the output register follow as registered stages
// before the character shows on the master side.
// Stall: while the master side is held off, the three back stages and the
// four-entry queue fill; tready on the slave side drops when the queue is
// full. Reset clears positions, queue and pipeline and loads 1x1 image and
// output sizes with three channels.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_to_ascii_downsampler_core #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_wr_en,
    input  wire [pxa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [pxa_pkg::CFG_W-1:0]           i_cfg_data,
    // pixel stream
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire [23:0]                         i_s_axis_tdata,   // comp_red, comp_green, comp_blue
    // character stream
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [31:0]                        o_m_axis_tdata,   // char_code, out_column, out_line
    output logic                               o_m_axis_tlast,   // row_end
    output logic                               o_m_axis_tuser    // frame_end
);

    pxa_pkg::t_pxa_cfg   r_cfg;
    pxa_pkg::t_pxa_item  push_item, q_item;
    logic                push, q_full, q_valid, q_pop;
    logic [pxa_pkg::CHAR_W-1:0]  out_char;
    logic [pxa_pkg::COORD_W-1:0] out_col, out_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= 13'd1;
            r_cfg.image_height  <= 13'd1;
            r_cfg.out_width     <= 13'd1;
            r_cfg.out_height    <= 13'd1;
            r_cfg.channel_count <= 3'd3;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pxa_pkg::REG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data;
                pxa_pkg::REG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data;
                pxa_pkg::REG_OUT_WIDTH:     r_cfg.out_width     <= i_cfg_data;
                pxa_pkg::REG_OUT_HEIGHT:    r_cfg.out_height    <= i_cfg_data;
                pxa_pkg::REG_CHANNEL_COUNT:
                    r_cfg.channel_count <= i_cfg_data[pxa_pkg::CHAN_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    pxa_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_wr_en),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .i_full  (q_full),
        .o_push  (push),
        .o_item  (push_item)
    );

    pxa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pxa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (out_char),
        .o_column    (out_col),
        .o_line      (out_line),
        .o_row_end   (o_m_axis_tlast),
        .o_frame_end (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, out_line, out_col, out_char};

endmodule

`default_nettype wire
